// File: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_SET   = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

endpackage

// File: sv/tcw_screen_ram.sv
// Screen cell store: one write port, one read port, registered read data.
module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]  o_rd_data
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/text_console_writer.sv
// Text console writer: character-cell screen store with cursor, top level.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one command per transfer:
//   write character, clear screen, set cursor or read cell. Every command
//   gives exactly one result transfer on o_out_valid / i_out_ready, holding
//   the cursor after the command, the cell read, and scroll / ignore flags.
//   The attribute register is written through i_cfg_wr_en / i_cfg_wr_data
//   with no handshake; write it only while the block is idle.
// Sequencing and throughput
//   Character writes, newlines and set-cursor commands: result registered in the
//   cycle after the transfer, one command per cycle while results are taken (one store write).
//   Read cell: the store's registered read data is captured in S_READ, then the result.
//   Clear screen, and any write that passes the bottom row: one sweep over
//   every cell of the store, one cell a cycle, then the result; no command
//   is taken during the sweep.
// Reset
//   After reset the store is filled with blank cells (0x0720) by a pass over
//   every cell; o_in_ready stays low meanwhile. Attribute writes are taken
//   as usual during that pass.
// Stalls
//   The result sits in an output register; a new command is taken when it is
//   empty or in the same cycle as that result transfers, otherwise input waits.
module text_console_writer #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]   i_target_row,
    input  logic [tcw_pkg::COL_W-1:0]   i_target_column,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]   o_cursor_column,
    output logic [tcw_pkg::POS_W-1:0]   o_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_value,
    output logic                        o_scrolled,
    output logic                        o_ignored
);

    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int POS_W  = tcw_pkg::POS_W;
    localparam int CELL_W = tcw_pkg::CELL_W;
    localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LIN_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SHIFT_END = ADDR_W'(CELLS - SCREEN_WIDTH);
    localparam logic [LIN_W-1:0]  WIDTH_L   = LIN_W'(SCREEN_WIDTH);
    localparam logic [ROW_W:0]    ROW_LIMIT = (ROW_W + 1)'(SCREEN_HEIGHT);
    localparam logic [COL_W:0]    COL_LIMIT = (COL_W + 1)'(SCREEN_WIDTH);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_HEIGHT - 1);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SWEEP
    } t_state;

    t_state                 r_state;
    logic [ADDR_W-1:0]      r_idx;
    logic                   r_shift;
    logic                   r_pend;
    logic [ADDR_W-1:0]      r_pend_addr;
    logic                   r_pend_mem;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic [ROW_W-1:0]       r_row;
    logic [COL_W-1:0]       r_col;

    logic                   r_ov;
    logic [ROW_W-1:0]       r_o_row;
    logic [COL_W-1:0]       r_o_col;
    logic [POS_W-1:0]       r_o_pos;
    logic [CELL_W-1:0]      r_o_cell;
    logic                   r_o_scr;
    logic                   r_o_ign;

    tcw_pkg::t_mode         mode;
    logic                   accept;
    logic                   is_newline;
    logic [COL_W:0]         col_inc;
    logic [ROW_W:0]         row_inc;
    logic                   wrap;
    logic                   past_bottom;
    logic                   target_ok;
    logic [ROW_W-1:0]       n_row;
    logic [COL_W-1:0]       n_col;
    logic [ROW_W-1:0]       res_row;
    logic [COL_W-1:0]       res_col;
    logic [LIN_W-1:0]       cur_lin;
    logic [LIN_W-1:0]       tgt_lin;
    logic [LIN_W-1:0]       res_lin;
    logic [LIN_W-1:0]       sweep_src;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_wa;
    logic [CELL_W-1:0]      ram_wd;
    logic [ADDR_W-1:0]      ram_ra;
    logic [CELL_W-1:0]      ram_rd;

    // Take a command only when idle, no sweep write pending, and the result
    // register is free or transfers this cycle.
    assign o_in_ready = (r_state == S_IDLE) && !r_pend && (!r_ov || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign mode       = tcw_pkg::t_mode'(i_mode);

    // Cursor advance for a character write or newline
    assign is_newline  = (i_char_code == tcw_pkg::NEWLINE_CHAR);
    assign col_inc     = {1'b0, r_col} + 1'b1;
    assign row_inc     = {1'b0, r_row} + 1'b1;
    assign wrap        = is_newline || (col_inc >= COL_LIMIT);
    assign past_bottom = wrap && (row_inc >= ROW_LIMIT);
    assign target_ok   = ({1'b0, i_target_row} < ROW_LIMIT)
                      && ({1'b0, i_target_column} < COL_LIMIT);

    always_comb begin
        n_row = r_row;
        n_col = col_inc[COL_W-1:0];
        if (wrap) begin
            n_col = '0;
            n_row = past_bottom ? ROW_LAST : row_inc[ROW_W-1:0];
        end
    end

    // Cursor reported with the result, per command
    always_comb begin
        res_row = r_row;
        res_col = r_col;
        unique case (mode)
            tcw_pkg::MODE_WRITE: begin
                res_row = n_row;
                res_col = n_col;
            end
            tcw_pkg::MODE_CLEAR: begin
                res_row = '0;
                res_col = '0;
            end
            tcw_pkg::MODE_SET: begin
                if (target_ok) begin
                    res_row = i_target_row;
                    res_col = i_target_column;
                end
            end
            tcw_pkg::MODE_READ: begin
                res_row = r_row;
                res_col = r_col;
            end
            default: begin
                res_row = r_row;
                res_col = r_col;
            end
        endcase
    end

    assign cur_lin   = LIN_W'(r_row) * WIDTH_L + LIN_W'(r_col);
    assign tgt_lin   = LIN_W'(i_target_row) * WIDTH_L + LIN_W'(i_target_column);
    assign res_lin   = LIN_W'(res_row) * WIDTH_L + LIN_W'(res_col);
    assign sweep_src = LIN_W'(r_idx) + WIDTH_L;

    // Store write port: reset fill, then the delayed sweep write, then a
    // character write from an accepted command.
    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_idx;
        ram_wd = tcw_pkg::RESET_CELL;
        if (r_state == S_INIT) begin
            ram_we = 1'b1;
        end else if (r_pend) begin
            ram_we = 1'b1;
            ram_wa = r_pend_addr;
            ram_wd = r_pend_mem ? ram_rd : {r_attr, tcw_pkg::BLANK_CHAR};
        end else if (accept && (mode == tcw_pkg::MODE_WRITE) && !is_newline) begin
            ram_we = 1'b1;
            ram_wa = cur_lin[ADDR_W-1:0];
            ram_wd = {r_attr, i_char_code};
        end
    end

    // Read one row ahead while sweeping; otherwise read the target cell
    assign ram_ra = (r_state == S_SWEEP) ? sweep_src[ADDR_W-1:0] : tgt_lin[ADDR_W-1:0];

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::RESET_ATTR;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_shift <= 1'b0;
            r_pend  <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_CELL) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (accept) begin
                        r_row    <= res_row;
                        r_col    <= res_col;
                        r_o_row  <= res_row;
                        r_o_col  <= res_col;
                        r_o_pos  <= res_lin[POS_W-1:0];
                        r_o_cell <= '0;
                        r_o_scr  <= (mode == tcw_pkg::MODE_WRITE) && past_bottom;
                        r_o_ign  <= ((mode == tcw_pkg::MODE_SET)
                                     || (mode == tcw_pkg::MODE_READ)) && !target_ok;
                        unique case (mode)
                            tcw_pkg::MODE_WRITE: begin
                                if (past_bottom) begin
                                    r_shift <= 1'b1;
                                    r_idx   <= '0;
                                    r_state <= S_SWEEP;
                                end else begin
                                    r_ov <= 1'b1;
                                end
                            end
                            tcw_pkg::MODE_CLEAR: begin
                                r_shift <= 1'b0;
                                r_idx   <= '0;
                                r_state <= S_SWEEP;
                            end
                            tcw_pkg::MODE_SET: begin
                                r_ov <= 1'b1;
                            end
                            tcw_pkg::MODE_READ: begin
                                if (target_ok) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_ov <= 1'b1;
                                end
                            end
                            default: begin
                                r_ov <= 1'b1;
                            end
                        endcase
                    end
                end

                S_READ: begin
                    r_o_cell <= ram_rd;
                    r_ov     <= 1'b1;
                    r_state  <= S_IDLE;
                end

                S_SWEEP: begin
                    // Write lands in the next cycle, once the source row is read
                    r_pend      <= 1'b1;
                    r_pend_addr <= r_idx;
                    r_pend_mem  <= r_shift && (r_idx < SHIFT_END);
                    r_idx       <= r_idx + 1'b1;
                    if (r_idx == LAST_CELL) begin
                        r_idx   <= '0;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_ov;
    assign o_cursor_row      = r_o_row;
    assign o_cursor_column   = r_o_col;
    assign o_cursor_position = r_o_pos;
    assign o_cell_value      = r_o_cell;
    assign o_scrolled        = r_o_scr;
    assign o_ignored         = r_o_ign;

endmodule
